@@ design/iirdf1_pkg.sv @@
// Shared types, constants and helpers for the direct-form-I IIR filter.
// Used by the configuration block, the filter core and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package iirdf1_pkg;

    // Default widths for the top-level parameters.
    localparam int DEF_SAMPLE_WIDTH   = 16;
    localparam int DEF_COEF_FRAC_BITS = 14;

    // Highest tap count the filter supports (second order).
    localparam int MAX_TAPS = 3;

    // Width of the configuration register index.
    localparam int CFG_INDEX_WIDTH = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_B0_COEF      = 3'd0,
        CFG_B1_COEF      = 3'd1,
        CFG_B2_COEF      = 3'd2,
        CFG_A1_COEF      = 3'd3,
        CFG_A2_COEF      = 3'd4,
        CFG_FWD_TAPS     = 3'd5,
        CFG_FB_TAPS      = 3'd6
    } t_cfg_index;

    // Which optional taps take part in the sum.
    typedef struct packed {
        logic b1_en;
        logic b2_en;
        logic a1_en;
        logic a2_en;
    } t_tap_en;

    // A count of zero acts as one; a count above MAX_TAPS acts as MAX_TAPS.
    function automatic logic [1:0] clamp_count(input logic [1:0] count);
        logic [1:0] result;
        result = count;
        if (count == 2'd0) begin
            result = 2'd1;
        end else if (count > 2'(MAX_TAPS)) begin
            result = 2'(MAX_TAPS);
        end
        return result;
    endfunction

endpackage

@@ design/iirdf1_cfg_regs.sv @@
// Configuration registers of the IIR filter: five coefficients and two tap counts.
// Decodes the tap counts into tap enables for the filter core.
// Depends on iirdf1_pkg.
`timescale 1ns / 1ps

module iirdf1_cfg_regs import iirdf1_pkg::*; #(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    localparam int COEF_WIDTH    = COEF_FRAC_BITS + 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [COEF_WIDTH-1:0]        i_cfg_data,
    output logic signed [COEF_WIDTH-1:0] o_b0,
    output logic signed [COEF_WIDTH-1:0] o_b1,
    output logic signed [COEF_WIDTH-1:0] o_b2,
    output logic signed [COEF_WIDTH-1:0] o_a1,
    output logic signed [COEF_WIDTH-1:0] o_a2,
    output t_tap_en                      o_tap_en
);

    logic signed [COEF_WIDTH-1:0] r_b0;
    logic signed [COEF_WIDTH-1:0] r_b1;
    logic signed [COEF_WIDTH-1:0] r_b2;
    logic signed [COEF_WIDTH-1:0] r_a1;
    logic signed [COEF_WIDTH-1:0] r_a2;
    logic [1:0]                   r_fwd_taps;
    logic [1:0]                   r_fb_taps;
    logic [1:0]                   w_fwd_cnt;
    logic [1:0]                   w_fb_cnt;

    // Register writes; b0 resets to unity gain, other coefficients to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0       <= COEF_WIDTH'(1) << COEF_FRAC_BITS;
            r_b1       <= '0;
            r_b2       <= '0;
            r_a1       <= '0;
            r_a2       <= '0;
            r_fwd_taps <= 2'd3;
            r_fb_taps  <= 2'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_B0_COEF:  r_b0       <= i_cfg_data;
                CFG_B1_COEF:  r_b1       <= i_cfg_data;
                CFG_B2_COEF:  r_b2       <= i_cfg_data;
                CFG_A1_COEF:  r_a1       <= i_cfg_data;
                CFG_A2_COEF:  r_a2       <= i_cfg_data;
                CFG_FWD_TAPS: r_fwd_taps <= i_cfg_data[1:0];
                CFG_FB_TAPS:  r_fb_taps  <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Turn the clamped counts into per-tap enables.
    always_comb begin
        w_fwd_cnt      = clamp_count(r_fwd_taps);
        w_fb_cnt       = clamp_count(r_fb_taps);
        o_tap_en.b1_en = (w_fwd_cnt >= 2'd2);
        o_tap_en.b2_en = (w_fwd_cnt >= 2'd3);
        o_tap_en.a1_en = (w_fb_cnt >= 2'd2);
        o_tap_en.a2_en = (w_fb_cnt >= 2'd3);
    end

    assign o_b0 = r_b0;
    assign o_b1 = r_b1;
    assign o_b2 = r_b2;
    assign o_a1 = r_a1;
    assign o_a2 = r_a2;

endmodule

@@ design/iirdf1_core.sv @@
// Filter core: input and output history, five parallel multipliers, the sum,
// rounding and saturation. Histories shift whenever a sample is processed.
// Depends on iirdf1_pkg.
`timescale 1ns / 1ps

module iirdf1_core import iirdf1_pkg::*; #(
    parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    localparam int COEF_WIDTH    = COEF_FRAC_BITS + 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [COEF_WIDTH-1:0]   i_b0,
    input  logic signed [COEF_WIDTH-1:0]   i_b1,
    input  logic signed [COEF_WIDTH-1:0]   i_b2,
    input  logic signed [COEF_WIDTH-1:0]   i_a1,
    input  logic signed [COEF_WIDTH-1:0]   i_a2,
    input  t_tap_en                        i_tap_en,
    output logic signed [SAMPLE_WIDTH-1:0] o_y,
    output logic                           o_sat
);

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    // Five products need three guard bits.
    localparam int ACC_W  = PROD_W + 3;
    localparam int SH_W   = ACC_W - COEF_FRAC_BITS;
    localparam logic signed [SH_W-1:0] Y_MAX =
        {{(SH_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SH_W-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic signed [SAMPLE_WIDTH-1:0] r_x1;
    logic signed [SAMPLE_WIDTH-1:0] r_x2;
    logic signed [SAMPLE_WIDTH-1:0] r_y1;
    logic signed [SAMPLE_WIDTH-1:0] r_y2;

    logic signed [PROD_W-1:0] w_p_b0;
    logic signed [PROD_W-1:0] w_p_b1;
    logic signed [PROD_W-1:0] w_p_b2;
    logic signed [PROD_W-1:0] w_p_a1;
    logic signed [PROD_W-1:0] w_p_a2;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  w_rounded;
    logic signed [SH_W-1:0]   w_shifted;
    logic                     w_sat_hi;
    logic                     w_sat_lo;

    // One multiplier per tap, all in parallel.
    always_comb begin
        w_p_b0 = PROD_W'(i_b0) * PROD_W'(i_x);
        w_p_b1 = PROD_W'(i_b1) * PROD_W'(r_x1);
        w_p_b2 = PROD_W'(i_b2) * PROD_W'(r_x2);
        w_p_a1 = PROD_W'(i_a1) * PROD_W'(r_y1);
        w_p_a2 = PROD_W'(i_a2) * PROD_W'(r_y2);
    end

    // Sum of the enabled taps; feedback terms are subtracted.
    always_comb begin
        w_acc = ACC_W'(w_p_b0);
        if (i_tap_en.b1_en) begin
            w_acc = w_acc + ACC_W'(w_p_b1);
        end
        if (i_tap_en.b2_en) begin
            w_acc = w_acc + ACC_W'(w_p_b2);
        end
        if (i_tap_en.a1_en) begin
            w_acc = w_acc - ACC_W'(w_p_a1);
        end
        if (i_tap_en.a2_en) begin
            w_acc = w_acc - ACC_W'(w_p_a2);
        end
    end

    // Round half up, drop the fraction, then clip to the sample range.
    always_comb begin
        w_rounded = w_acc + ROUND_HALF;
        w_shifted = w_rounded[ACC_W-1:COEF_FRAC_BITS];
        w_sat_hi  = (w_shifted > Y_MAX);
        w_sat_lo  = (w_shifted < Y_MIN);
        o_sat     = w_sat_hi | w_sat_lo;
        if (w_sat_hi) begin
            o_y = Y_MAX[SAMPLE_WIDTH-1:0];
        end else if (w_sat_lo) begin
            o_y = Y_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            o_y = w_shifted[SAMPLE_WIDTH-1:0];
        end
    end

    // Both histories shift on every processed sample, whatever the tap counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_step) begin
            r_x2 <= r_x1;
            r_x1 <= i_x;
            r_y2 <= r_y1;
            r_y1 <= o_y;
        end
    end

endmodule

@@ design/iir_direct_form_one_filter_unit.sv @@
// Top level of the direct-form-I IIR filter: request handshakes, input and
// result registers, configuration registers and the filter core.
// Depends on iirdf1_pkg, iirdf1_cfg_regs and iirdf1_core.
`timescale 1ns / 1ps

// Second-order direct-form-I IIR filter, one result per input sample.
// Input channel: i_valid / o_ready with i_sample_in. A request is taken at a
// rising edge with both high and lands in the input register.
// Output channel: o_valid / i_ready with o_filtered_sample and o_saturated.
// Path: a taken request lands in the input register, the filter pass settles
// from there, and the result register takes the result once it is free or
// drains; the result is then offered on o_valid.
// Throughput: one sample per cycle while the receiver keeps i_ready high. The recursion
// from the previous output through the multipliers, sum, rounding and saturation back
// into the output history is combinational, so nothing limits the rate below that.
// Stall: when the receiver holds i_ready low, the result waits in the result
// register and one more request is still taken into the input register; after
// that o_ready drops until the result is taken.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index in the
// same edge; write only while no sample is in flight.
// Reset (synchronous, i_rst_n low): both registers empty, histories cleared,
// b0 = 1.0, other coefficients zero, all three forward taps, no feedback.
module iir_direct_form_one_filter_unit import iirdf1_pkg::*; #(
    parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    localparam int COEF_WIDTH    = COEF_FRAC_BITS + 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered_sample,
    output logic                           o_saturated,
    input  logic                           i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]     i_cfg_index,
    input  logic [COEF_WIDTH-1:0]          i_cfg_data
);

    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic                           r_sat;
    logic                           w_step;
    logic signed [SAMPLE_WIDTH-1:0] w_y;
    logic                           w_sat;
    logic signed [COEF_WIDTH-1:0]   w_b0;
    logic signed [COEF_WIDTH-1:0]   w_b1;
    logic signed [COEF_WIDTH-1:0]   w_b2;
    logic signed [COEF_WIDTH-1:0]   w_a1;
    logic signed [COEF_WIDTH-1:0]   w_a2;
    t_tap_en                        w_tap_en;

    // A sample moves into the result register when that register is free or drains.
    assign w_step  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_step;

    iirdf1_cfg_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_b0        (w_b0),
        .o_b1        (w_b1),
        .o_b2        (w_b2),
        .o_a1        (w_a1),
        .o_a2        (w_a2),
        .o_tap_en    (w_tap_en)
    );

    iirdf1_core #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_x      (r_x),
        .i_b0     (w_b0),
        .i_b1     (w_b1),
        .i_b2     (w_b2),
        .i_a1     (w_a1),
        .i_a2     (w_a2),
        .i_tap_en (w_tap_en),
        .o_y      (w_y),
        .o_sat    (w_sat)
    );

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x <= i_sample_in;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_y   <= w_y;
            r_sat <= w_sat;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_filtered_sample = r_y;
    assign o_saturated       = r_sat;

endmodule

@@ tb/iir_direct_form_one_filter_unit_tb.sv @@
// Self-checking testbench for the direct-form-I IIR filter unit: directed rows, then
// random filter settings and samples with random request gaps and receiver stalls.
// Depends on iirdf1_pkg and iir_direct_form_one_filter_unit.
`timescale 1ns / 1ps

module iir_direct_form_one_filter_unit_tb import iirdf1_pkg::*; ();

    localparam int SW = DEF_SAMPLE_WIDTH;
    localparam int FRAC = DEF_COEF_FRAC_BITS;
    localparam int CW = FRAC + 4;

    localparam int RANDOM_ITEMS = 1530;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // The index above the last register; writes to it must change nothing.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_INDEX = 3'd7;

    localparam longint OUT_MAX = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;
    localparam logic [CW-1:0] COEF_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0] COEF_MIN = {1'b1, {(CW - 1){1'b0}}};
    localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 clipped;
    } t_filter_result;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [CFG_INDEX_WIDTH-1:0] idx;
        logic [CW-1:0]              data;
        logic signed [SW-1:0]       sample;
        logic                       typed;
        logic signed [SW-1:0]       want_value;
        logic                       want_clipped;
    } t_directed_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SW-1:0]       i_sample_in;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [SW-1:0]       o_filtered_sample;
    logic                       o_saturated;
    logic                       i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CW-1:0]              i_cfg_data;

    // Filter settings and history as the block should hold them.
    logic signed [CW-1:0] coef_model [5];
    logic [1:0]           fwd_taps_model;
    logic [1:0]           fb_taps_model;
    logic signed [SW-1:0] x_hist [2];
    logic signed [SW-1:0] y_hist [2];

    t_filter_result pending_outputs [$];
    t_filter_result oldest_result;
    int             mismatch_count;
    int             quiet_cycles;
    int             rx_stall_left;
    bit             tx_gaps_on;
    bit             rx_stalls_on;

    // Directed rows: reset defaults, sample and coefficient extremes, rounding of
    // halves, zero tap counts, upper data bits on count writes, and feedback.
    localparam int DIRECTED_ROWS = 35;
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sd0, 1'b1, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sh8000, 1'b1, 16'sh8000, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'shFFFF, 1'b1, 16'shFFFF, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sd12345, 1'b1, 16'sd12345, 1'b0},
        '{ROW_WRITE, CFG_B0_COEF, 18'h1FFFF, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sh8000, 1'b1, 16'sh8000, 1'b1},
        '{ROW_WRITE, CFG_B0_COEF, 18'h20000, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sh8000, 1'b1, 16'sh7FFF, 1'b1},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sh7FFF, 1'b1, 16'sh8000, 1'b1},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sd0, 1'b1, 16'sd0, 1'b0},
        '{ROW_WRITE, CFG_B0_COEF, 18'd8192, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sd1, 1'b1, 16'sd1, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'shFFFF, 1'b1, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sd3, 1'b1, 16'sd2, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'shFFFD, 1'b1, 16'shFFFF, 1'b0},
        '{ROW_WRITE, CFG_FWD_TAPS, 18'h3FFF0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, CFG_B1_COEF, 18'd16384, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, CFG_B2_COEF, 18'h3C000, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, CFG_A1_COEF, 18'h3C000, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, CFG_A2_COEF, 18'd8192, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, CFG_B0_COEF, 18'd16384, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sd1000, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, CFG_FWD_TAPS, 18'h2AAAB, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, CFG_FB_TAPS, 18'h3FFFE, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'shF830, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sh7FFF, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sh7FFF, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, CFG_FB_TAPS, 18'h00003, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sh8000, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sd5, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, CFG_FWD_TAPS, 18'h3FFFE, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sd7, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_B0_COEF, 18'd0, 16'sh8000, 1'b0, 16'sd0, 1'b0}
    };

    iir_direct_form_one_filter_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample_in       (i_sample_in),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_filtered_sample (o_filtered_sample),
        .o_saturated       (o_saturated),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // One filter step: full-precision sum over the enabled taps, round half up,
    // saturate, then shift both histories whatever the tap counts are.
    function automatic t_filter_result filter_step(input logic signed [SW-1:0] x);
        longint acc;
        longint rounded;
        int fwd_n;
        int fb_n;
        t_filter_result res;
        fwd_n = (fwd_taps_model == 2'd0) ? 1 : int'(fwd_taps_model);
        fb_n = (fb_taps_model == 2'd0) ? 1 : int'(fb_taps_model);
        if (fwd_n > MAX_TAPS) fwd_n = MAX_TAPS;
        if (fb_n > MAX_TAPS) fb_n = MAX_TAPS;
        acc = longint'(coef_model[CFG_B0_COEF]) * longint'(x);
        if (fwd_n >= 2) acc += longint'(coef_model[CFG_B1_COEF]) * longint'(x_hist[0]);
        if (fwd_n >= 3) acc += longint'(coef_model[CFG_B2_COEF]) * longint'(x_hist[1]);
        if (fb_n >= 2) acc -= longint'(coef_model[CFG_A1_COEF]) * longint'(y_hist[0]);
        if (fb_n >= 3) acc -= longint'(coef_model[CFG_A2_COEF]) * longint'(y_hist[1]);
        acc += longint'(1) <<< (FRAC - 1);
        rounded = acc >>> FRAC;
        res.clipped = 1'b0;
        if (rounded > OUT_MAX) begin
            res.value = SAMPLE_MAX;
            res.clipped = 1'b1;
        end else if (rounded < OUT_MIN) begin
            res.value = SAMPLE_MIN;
            res.clipped = 1'b1;
        end else begin
            res.value = SW'(rounded);
        end
        x_hist[1] = x_hist[0];
        x_hist[0] = x;
        y_hist[1] = y_hist[0];
        y_hist[0] = res.value;
        return res;
    endfunction

    // Mostly back-to-back requests, some short gaps and a few long ones.
    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (!tx_gaps_on || pick < 65) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int receiver_stall();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SW-1:0] random_sample();
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        unique case (pick)
            0: begin
                unique case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3, 4: return SW'($urandom);
            default: begin
                v = int'($urandom_range(0, 4000)) - 2000;
                return SW'(v);
            end
        endcase
    endfunction

    // Feedback coefficients are small or zero half of the time, so the filter is often
    // stable and the output is not pinned at a rail.
    function automatic logic [CW-1:0] random_coef(input bit feedback);
        int pick;
        int v;
        pick = $urandom_range(0, 7);
        unique case (pick)
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3, 4: return CW'($urandom);
            default: begin
                if (feedback) v = int'($urandom_range(0, 14000)) - 7000;
                else v = int'($urandom_range(0, 40000)) - 20000;
                return CW'(v);
            end
        endcase
    endfunction

    // Register write; only called while no request is in flight.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [CW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        unique case (idx)
            CFG_B0_COEF, CFG_B1_COEF, CFG_B2_COEF, CFG_A1_COEF, CFG_A2_COEF: begin
                coef_model[idx] = data;
            end
            CFG_FWD_TAPS: fwd_taps_model = data[1:0];
            CFG_FB_TAPS: fb_taps_model = data[1:0];
            default: ;
        endcase
    endtask

    // Offer one sample request and hold it until taken; the expected result is
    // the typed one where given, the predicted one otherwise.
    task automatic send_sample(input logic signed [SW-1:0] value, input bit has_typed,
                               input t_filter_result typed);
        int gap;
        t_filter_result predicted;
        gap = sender_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_in <= value;
        do @(posedge i_clk); while (!o_ready);
        predicted = filter_step(value);
        pending_outputs.push_back(has_typed ? typed : predicted);
    endtask

    // Stop sending and wait until every outstanding result has been taken.
    task automatic wait_for_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_outputs.size() != 0);
    endtask

    // Receiver: ready most of the time, with stalls of random length.
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            i_ready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
            rx_stall_left <= receiver_stall() - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare every taken result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outputs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected result: value %0d saturated %0b",
                             o_filtered_sample, o_saturated);
                end
            end else begin
                oldest_result = pending_outputs.pop_front();
                if (o_filtered_sample !== oldest_result.value ||
                        o_saturated !== oldest_result.clipped) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("result mismatch: expected %0d sat %0b, got %0d sat %0b",
                                 oldest_result.value, oldest_result.clipped,
                                 o_filtered_sample, o_saturated);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any request taken on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("FAIL iir_direct_form_one_filter_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int random_items;
        int phase_len;
        t_filter_result typed;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample_in = '0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        mismatch_count = 0;
        quiet_cycles = 0;
        rx_stall_left = 0;
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        random_items = 0;

        // Reset values of the filter settings and history.
        coef_model[CFG_B0_COEF] = CW'(1 << FRAC);
        coef_model[CFG_B1_COEF] = '0;
        coef_model[CFG_B2_COEF] = '0;
        coef_model[CFG_A1_COEF] = '0;
        coef_model[CFG_A2_COEF] = '0;
        fwd_taps_model = 2'd3;
        fb_taps_model = 2'd1;
        x_hist[0] = '0;
        x_hist[1] = '0;
        y_hist[0] = '0;
        y_hist[1] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                wait_for_idle();
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                typed.value = directed_rows[r].want_value;
                typed.clipped = directed_rows[r].want_clipped;
                send_sample(directed_rows[r].sample, directed_rows[r].typed, typed);
            end
        end

        // Random phases: new settings while idle, then a run of samples.
        typed = '0;
        while (random_items < RANDOM_ITEMS) begin
            wait_for_idle();
            if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_INDEX, CW'($urandom));
            write_reg(CFG_B0_COEF, random_coef(1'b0));
            write_reg(CFG_B1_COEF, random_coef(1'b0));
            write_reg(CFG_B2_COEF, random_coef(1'b0));
            write_reg(CFG_A1_COEF, random_coef(1'b1));
            write_reg(CFG_A2_COEF, random_coef(1'b1));
            write_reg(CFG_FWD_TAPS, CW'($urandom));
            write_reg(CFG_FB_TAPS, CW'($urandom));
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(20, 120);
            if (phase_len > RANDOM_ITEMS - random_items) begin
                phase_len = RANDOM_ITEMS - random_items;
            end
            repeat (phase_len) begin
                if ($urandom_range(0, 149) == 0) wait_for_idle();
                send_sample(random_sample(), 1'b0, typed);
                random_items++;
            end
        end

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outputs.size() == 0) begin
            $display("PASS iir_direct_form_one_filter_unit");
        end else begin
            $display("FAIL iir_direct_form_one_filter_unit");
        end
        $finish;
    end

endmodule
